@@ hdl/fut_pkg.sv @@
package fut_pkg;

    // Result bundle sizing: one input byte causes at most seven results
    localparam int MAX_RESULTS = 7;
    localparam int RES_IDX_W   = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BODY_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARRAYS      = 2'd2;

    localparam logic [15:0] FIELD_LIMIT_RST = 16'd8192;
    localparam logic [31:0] BODY_LIMIT_RST  = 32'd1048576;
    localparam logic        ARRAYS_RST      = 1'b1;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_NAME      = 3'd0,
        KIND_VALUE     = 3'd1,
        KIND_FIELD_END = 3'd2,
        KIND_BODY_END  = 3'd3,
        KIND_ERROR     = 3'd4
    } t_kind;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FIELD = 2'd1;
    localparam logic [1:0] ERR_BODY  = 2'd2;

    // Characters of the body syntax
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       mark;
        logic [1:0] err;
    } t_result;

    typedef struct packed {
        logic [RES_IDX_W-1:0]          count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

    typedef struct packed {
        logic [15:0] field_limit;
        logic [31:0] body_limit;
        logic        arrays;
    } t_cfg;

endpackage

@@ hdl/fut_front.sv @@
module fut_front #(
    parameter int FIELD_LEN_BITS = 16,
    parameter int BODY_LEN_BITS  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  fut_pkg::t_cfg    i_cfg,
    input  logic             i_full,
    output logic             o_stall,
    output logic             o_push,
    output fut_pkg::t_bundle o_bundle
);
    import fut_pkg::*;

    localparam int FCMP_W = (FIELD_LEN_BITS > 16) ? FIELD_LEN_BITS : 16;
    localparam int BCMP_W = (BODY_LEN_BITS > 32) ? BODY_LEN_BITS : 32;

    // Tokenizer state plus the results gathered for one byte
    typedef struct packed {
        logic                      in_value;
        logic                      pair_started;
        logic [1:0]                pct;
        logic [7:0]                fd;
        logic [7:0]                t0;
        logic [7:0]                t1;
        logic [1:0]                tcnt;
        logic                      mark;
        logic [RES_IDX_W-1:0]      n;
        t_result [MAX_RESULTS-1:0] res;
    } t_work;

    logic                      r_in_value;
    logic                      r_pair_started;
    logic [1:0]                r_pct;
    logic [7:0]                r_fd;
    logic [7:0]                r_t0;
    logic [7:0]                r_t1;
    logic [1:0]                r_tcnt;
    logic [FIELD_LEN_BITS-1:0] r_part_len;
    logic [BODY_LEN_BITS-1:0]  r_body_len;
    logic                      r_failed;

    t_work                     n_work;
    logic [FIELD_LEN_BITS-1:0] n_part_len;
    logic [BODY_LEN_BITS-1:0]  n_body_len;
    logic                      n_failed;
    logic                      accept;

    function automatic logic is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic t_work emit(t_work w, t_kind k, logic [7:0] d, logic m,
                                   logic [1:0] e);
        t_work v;
        v = w;
        v.res[v.n] = '{kind: k, data: d, mark: m, err: e};
        v.n = v.n + 1'b1;
        return v;
    endfunction

    // Value bytes go out at once; name bytes are held two deep
    function automatic t_work part_byte(t_work w, logic [7:0] b);
        t_work v;
        v = w;
        if (v.in_value) begin
            v = emit(v, KIND_VALUE, b, 1'b0, ERR_NONE);
        end else begin
            if (v.tcnt == 2'd2) begin
                v = emit(v, KIND_NAME, v.t0, 1'b0, ERR_NONE);
                v.t0   = v.t1;
                v.tcnt = 2'd1;
            end
            if (v.tcnt == 2'd0) v.t0 = b;
            else v.t1 = b;
            v.tcnt = v.tcnt + 2'd1;
        end
        return v;
    endfunction

    // Pass a pending escape through as literal bytes
    function automatic t_work flush(t_work w);
        t_work v;
        v = w;
        if (v.pct != 2'd0) v = part_byte(v, CH_PCT);
        if (v.pct == 2'd2) v = part_byte(v, v.fd);
        v.pct = 2'd0;
        return v;
    endfunction

    // Release held name bytes, or drop a trailing "[]" as array mark
    function automatic t_work name_end(t_work w, logic arrays);
        t_work v;
        v = w;
        if (arrays && v.tcnt == 2'd2 && v.t0 == CH_LBRACK && v.t1 == CH_RBRACK) begin
            v.mark = 1'b1;
        end else begin
            v.mark = 1'b0;
            if (v.tcnt != 2'd0) v = emit(v, KIND_NAME, v.t0, 1'b0, ERR_NONE);
            if (v.tcnt == 2'd2) v = emit(v, KIND_NAME, v.t1, 1'b0, ERR_NONE);
        end
        v.tcnt = 2'd0;
        return v;
    endfunction

    function automatic t_work field_finish(t_work w, logic arrays);
        t_work v;
        v = flush(w);
        if (v.in_value) v.mark = (v.tcnt == 2'd2);
        else v = name_end(v, arrays);
        if (v.pair_started) v = emit(v, KIND_FIELD_END, 8'd0, v.mark, ERR_NONE);
        v.in_value     = 1'b0;
        v.pair_started = 1'b0;
        v.tcnt         = 2'd0;
        return v;
    endfunction

    // Escape decoding and '+' to space
    function automatic t_work raw_byte(t_work w, logic [7:0] c);
        t_work v;
        logic  done;
        v    = w;
        done = 1'b0;
        if (v.pct == 2'd1) begin
            if (is_hex(c)) begin
                v.fd  = c;
                v.pct = 2'd2;
                done  = 1'b1;
            end else begin
                v = flush(v);
            end
        end else if (v.pct == 2'd2) begin
            if (is_hex(c)) begin
                v     = part_byte(v, {hex_val(v.fd), hex_val(c)});
                v.pct = 2'd0;
                done  = 1'b1;
            end else begin
                v = flush(v);
            end
        end
        if (!done) begin
            if (c == CH_PCT) v.pct = 2'd1;
            else if (c == CH_PLUS) v = part_byte(v, CH_SPACE);
            else v = part_byte(v, c);
        end
        return v;
    endfunction

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    // Work out the results and next state of one byte
    always_comb begin
        n_work = '{in_value: r_in_value, pair_started: r_pair_started, pct: r_pct,
                   fd: r_fd, t0: r_t0, t1: r_t1, tcnt: r_tcnt, mark: 1'b0,
                   n: '0, res: '0};
        n_part_len = r_part_len;
        n_body_len = r_body_len;
        n_failed   = r_failed;
        if (!r_failed) begin
            if (BCMP_W'(r_body_len) >= BCMP_W'(i_cfg.body_limit)) begin
                n_work   = emit(n_work, KIND_ERROR, 8'd0, 1'b0, ERR_BODY);
                n_failed = 1'b1;
            end else begin
                if (r_body_len != '1) n_body_len = r_body_len + 1'b1;
                if (i_byte == CH_AMP) begin
                    n_work     = field_finish(n_work, i_cfg.arrays);
                    n_part_len = '0;
                end else if (i_byte == CH_EQ && !n_work.in_value) begin
                    n_work.pair_started = 1'b1;
                    n_work              = flush(n_work);
                    n_work              = name_end(n_work, i_cfg.arrays);
                    n_work.in_value     = 1'b1;
                    n_work.tcnt         = n_work.mark ? 2'd2 : 2'd0;
                    n_part_len          = '0;
                end else if (FCMP_W'(r_part_len) >= FCMP_W'(i_cfg.field_limit)) begin
                    n_work   = emit(n_work, KIND_ERROR, 8'd0, 1'b0, ERR_FIELD);
                    n_failed = 1'b1;
                end else begin
                    if (r_part_len != '1) n_part_len = r_part_len + 1'b1;
                    n_work.pair_started = 1'b1;
                    n_work              = raw_byte(n_work, i_byte);
                end
                if (i_last && !n_failed) begin
                    n_work     = field_finish(n_work, i_cfg.arrays);
                    n_part_len = '0;
                    n_work     = emit(n_work, KIND_BODY_END, 8'd0, 1'b0, ERR_NONE);
                end
            end
        end
    end

    assign o_push   = accept && (n_work.n != '0);
    assign o_bundle = '{count: n_work.n, res: n_work.res};

    // Advance state on each transfer; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_in_value     <= 1'b0;
            r_pair_started <= 1'b0;
            r_pct          <= 2'd0;
            r_fd           <= 8'd0;
            r_t0           <= 8'd0;
            r_t1           <= 8'd0;
            r_tcnt         <= 2'd0;
            r_part_len     <= '0;
            r_body_len     <= '0;
            r_failed       <= 1'b0;
        end else if (accept) begin
            r_in_value     <= n_work.in_value;
            r_pair_started <= n_work.pair_started;
            r_pct          <= n_work.pct;
            r_fd           <= n_work.fd;
            r_t0           <= n_work.t0;
            r_t1           <= n_work.t1;
            r_tcnt         <= n_work.tcnt;
            r_part_len     <= n_part_len;
            r_body_len     <= n_body_len;
            r_failed       <= n_failed;
        end
    end

endmodule

@@ hdl/fut_queue.sv @@
module fut_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fut_pkg::t_bundle i_data,
    input  logic             i_pop,
    output fut_pkg::t_bundle o_data,
    output logic             o_full,
    output logic             o_empty
);
    import fut_pkg::*;

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    // Store a bundle on push
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

@@ hdl/fut_back.sv @@
module fut_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fut_pkg::t_bundle i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_array_mark,
    output logic [1:0]       o_error_code,
    output logic             o_run_last
);
    import fut_pkg::*;

    logic                 r_busy;
    t_bundle              r_bundle;
    logic [RES_IDX_W-1:0] r_idx;
    t_result              cur;
    logic                 at_end;
    logic                 done;

    assign cur    = r_bundle.res[r_idx];
    assign at_end = (r_idx == r_bundle.count - 1'b1);
    assign done   = r_busy && !i_stall && at_end;
    assign o_pop  = !i_empty && (!r_busy || done);

    assign o_valid      = r_busy;
    assign o_kind       = cur.kind;
    assign o_out_byte   = cur.data;
    assign o_array_mark = cur.mark;
    assign o_error_code = cur.err;
    assign o_run_last   = at_end;

    // Hold the current bundle and step through its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && !i_stall) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_bundle <= i_head;
    end

endmodule

@@ hdl/form_urlencoded_tokenizer.sv @@
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_stall    i_body_byte, i_body_last
// output    o_out_valid / i_out_stall  o_kind, o_out_byte, o_array_mark,
//                                      o_error_code, o_run_last
// config    i_cfg_we                   i_cfg_index, i_cfg_data
//
// The front takes one body byte per cycle while the result queue has room.
// A byte with k results (up to seven) holds the back until all k are out,
// one result per cycle while i_out_stall is low; the four-entry bundle queue
// sets how long a burst of such bytes can run before the input stalls.
// Reset is synchronous: it empties the queue and restores the register
// defaults; no clearing pass follows.
module form_urlencoded_tokenizer #(
    parameter int FIELD_LEN_BITS = 16,
    parameter int BODY_LEN_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_body_byte,
    input  logic                           i_body_last,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_kind,
    output logic [7:0]                     o_out_byte,
    output logic                           o_array_mark,
    output logic [1:0]                     o_error_code,
    output logic                           o_run_last,
    input  logic                           i_cfg_we,
    input  logic [fut_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fut_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fut_pkg::*;

    t_cfg    r_cfg;
    t_bundle push_bundle;
    t_bundle head_bundle;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_limit <= FIELD_LIMIT_RST;
            r_cfg.body_limit  <= BODY_LIMIT_RST;
            r_cfg.arrays      <= ARRAYS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIELD_LIMIT: r_cfg.field_limit <= i_cfg_data[15:0];
                CFG_BODY_LIMIT:  r_cfg.body_limit  <= i_cfg_data[31:0];
                CFG_ARRAYS:      r_cfg.arrays      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    fut_front #(
        .FIELD_LEN_BITS (FIELD_LEN_BITS),
        .BODY_LEN_BITS  (BODY_LEN_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_byte   (i_body_byte),
        .i_last   (i_body_last),
        .i_cfg    (r_cfg),
        .i_full   (full),
        .o_stall  (o_in_stall),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    fut_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bundle),
        .i_pop   (pop),
        .o_data  (head_bundle),
        .o_full  (full),
        .o_empty (empty)
    );

    fut_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_bundle),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_array_mark (o_array_mark),
        .o_error_code (o_error_code),
        .o_run_last   (o_run_last)
    );

endmodule

@@ hdl/fut_checker.sv @@
module fut_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [2:0]                      o_kind,
    input logic [7:0]                      o_out_byte,
    input logic                            o_run_last
);
    import fut_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kind) && $stable(o_out_byte))
        else $error("stalled result changed");

    // Nothing to deliver right after reset
    a_reset_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // Queue is empty after reset, so input is not stalled
    a_reset_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_stall)
        else $error("input stalled right after reset");

    // Body end and error are always the final result of their byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_BODY_END || o_kind == KIND_ERROR) |-> o_run_last)
        else $error("body end or error not marked last");

endmodule

bind form_urlencoded_tokenizer fut_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_out_byte  (o_out_byte),
    .o_run_last  (o_run_last)
);
